### rtl/core/assert_macros.svh
// assertion macros shared by the tokenizer rtl
// expects clock and reset in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset
`define HRT_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// checked on every clock edge, reset included
`define HRT_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

### rtl/core/hrt_pkg.sv
// types, constants and helper functions of the request tokenizer
// no dependencies
package hrt_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int MAX_RESULTS = 3;
   localparam int CNT_W = $clog2(MAX_RESULTS + 1);
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_ADDR_W-1:0] ADDR_URL_DECODE = 2'd0;

   localparam logic [7:0] CH_LF = 8'd10;
   localparam logic [7:0] CH_CR = 8'd13;
   localparam logic [7:0] CH_SP = 8'd32;
   localparam logic [7:0] CH_PCT = 8'd37;
   localparam logic [7:0] CH_COLON = 8'd58;

   typedef enum logic [2:0] {
      PH_METHOD  = 3'd0,
      PH_URL     = 3'd1,
      PH_VERSION = 3'd2,
      PH_KEY     = 3'd3,
      PH_VALUE   = 3'd4
   } hrt_phase_type;

   typedef enum logic [2:0] {
      TAG_METHOD   = 3'd0,
      TAG_URL      = 3'd1,
      TAG_VERSION  = 3'd2,
      TAG_KEY      = 3'd3,
      TAG_VALUE    = 3'd4,
      TAG_LINE_END = 3'd5,
      TAG_REQ_END  = 3'd6,
      TAG_ERROR    = 3'd7
   } hrt_tag_type;

   typedef struct packed {
      logic [7:0]  data;
      hrt_tag_type tag;
      logic        ok;
      logic        err;
   } hrt_result_type;

   typedef struct packed {
      logic [CNT_W-1:0]                 cnt;
      hrt_result_type [MAX_RESULTS-1:0] res;
   } hrt_entry_type;

   typedef struct packed {
      hrt_phase_type phase;
      logic          pending_cr;
      logic          pending_colon;
      logic [1:0]    pct_cnt;
      logic [7:0]    pct_digit;
      logic          line_ne;
      logic          key_ne;
      logic          val_ne;
   } hrt_state_type;

   typedef struct packed {
      logic       valid;
      logic [3:0] val;
   } hrt_hex_type;

   function automatic hrt_hex_type hex_val(input logic [7:0] c);
      hrt_hex_type h;
      h = '0;
      if (c >= 8'd48 && c <= 8'd57) begin
         h.valid = 1'b1;
         h.val = 4'(c - 8'd48);
      end else if (c >= 8'd97 && c <= 8'd102) begin
         h.valid = 1'b1;
         h.val = 4'(c - 8'd87);
      end else if (c >= 8'd65 && c <= 8'd70) begin
         h.valid = 1'b1;
         h.val = 4'(c - 8'd55);
      end
      return h;
   endfunction

endpackage

### rtl/core/hrt_req_if.sv
// request byte channel: valid, ready and one raw byte per beat
// no dependencies
interface hrt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink (input valid, input in_byte, output ready);
endinterface

### rtl/core/hrt_rsp_if.sv
// result channel: valid, ready and one tagged field byte per beat
// no dependencies
interface hrt_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic [2:0] field_tag;
   logic       header_ok;
   logic       error_code;
   logic       last;

   modport source (output valid, output out_byte, output field_tag, output header_ok,
                   output error_code, output last, input ready);
   modport sink (input valid, input out_byte, input field_tag, input header_ok,
                 input error_code, input last, output ready);
endinterface

### rtl/core/hrt_queue.sv
// short queue of result groups between tokenizer front and back
// depends on hrt_pkg and assert_macros.svh
`include "assert_macros.svh"

module hrt_queue #(
   parameter int DEPTH = hrt_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  hrt_pkg::hrt_entry_type push_data,
   output logic               full,
   input  logic               pop,
   output hrt_pkg::hrt_entry_type head,
   output logic               empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   hrt_pkg::hrt_entry_type mem [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);
   assign head = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   `HRT_ASSERT(a_no_overflow, push |-> !full, "push into full result queue")
   `HRT_ASSERT(a_no_underflow, pop |-> !empty, "pop from empty result queue")

endmodule

### rtl/core/hrt_front.sv
// front of the tokenizer: takes request bytes, tracks the parse state and
// builds the group of results each byte causes; depends on hrt_pkg, hrt_req_if
module hrt_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   url_decode_enable,
   hrt_req_if.sink                req_bus,
   input  logic                   q_full,
   output logic                   q_push,
   output hrt_pkg::hrt_entry_type q_data
);

   typedef struct packed {
      hrt_pkg::hrt_state_type st;
      hrt_pkg::hrt_entry_type ent;
   } hrt_work_type;

   hrt_pkg::hrt_state_type st_ff, st_in;
   hrt_work_type w;
   logic accept;

   function automatic hrt_work_type put(input hrt_work_type x, input logic [7:0] d,
                                        input hrt_pkg::hrt_tag_type t, input logic ok,
                                        input logic err);
      hrt_work_type y;
      y = x;
      if (y.ent.cnt != hrt_pkg::CNT_W'(hrt_pkg::MAX_RESULTS)) begin
         y.ent.res[y.ent.cnt].data = d;
         y.ent.res[y.ent.cnt].tag = t;
         y.ent.res[y.ent.cnt].ok = ok;
         y.ent.res[y.ent.cnt].err = err;
         y.ent.cnt = y.ent.cnt + 1'b1;
      end
      return y;
   endfunction

   function automatic hrt_work_type emit_field(input hrt_work_type x, input logic [7:0] d);
      hrt_work_type y;
      y = x;
      y.st.line_ne = 1'b1;
      if (y.st.phase == hrt_pkg::PH_KEY) y.st.key_ne = 1'b1;
      if (y.st.phase == hrt_pkg::PH_VALUE) y.st.val_ne = 1'b1;
      y = put(y, d, hrt_pkg::hrt_tag_type'(y.st.phase), 1'b0, 1'b0);
      return y;
   endfunction

   function automatic hrt_work_type line_end(input hrt_work_type x);
      hrt_work_type y;
      y = x;
      if (y.st.phase == hrt_pkg::PH_METHOD || y.st.phase == hrt_pkg::PH_URL) begin
         y = put(y, 8'd0, hrt_pkg::TAG_ERROR, 1'b0, !y.st.line_ne);
         y.st.phase = hrt_pkg::PH_METHOD;
      end else if (y.st.phase == hrt_pkg::PH_VERSION) begin
         y = put(y, 8'd0, hrt_pkg::TAG_LINE_END, 1'b0, 1'b0);
         y.st.phase = hrt_pkg::PH_KEY;
      end else if (!y.st.line_ne) begin
         y = put(y, 8'd0, hrt_pkg::TAG_REQ_END, 1'b0, 1'b0);
         y.st.phase = hrt_pkg::PH_METHOD;
      end else begin
         y = put(y, 8'd0, hrt_pkg::TAG_LINE_END,
                 (y.st.phase == hrt_pkg::PH_VALUE) && y.st.key_ne && y.st.val_ne, 1'b0);
         y.st.phase = hrt_pkg::PH_KEY;
      end
      y.st.line_ne = 1'b0;
      y.st.key_ne = 1'b0;
      y.st.val_ne = 1'b0;
      y.st.pending_colon = 1'b0;
      y.st.pct_cnt = 2'd0;
      y.st.pct_digit = 8'd0;
      return y;
   endfunction

   function automatic hrt_work_type parse_byte(input hrt_work_type x, input logic [7:0] b,
                                               input logic en);
      hrt_work_type y;
      hrt_pkg::hrt_hex_type hx;
      hrt_pkg::hrt_hex_type hi;
      logic done;
      y = x;
      done = 1'b0;
      hx = hrt_pkg::hex_val(b);
      hi = hrt_pkg::hex_val(y.st.pct_digit);
      if (b != hrt_pkg::CH_CR) y.st.line_ne = 1'b1;
      // pending escape in the url
      if (y.st.phase == hrt_pkg::PH_URL && y.st.pct_cnt != 2'd0) begin
         if (hx.valid) begin
            if (y.st.pct_cnt == 2'd1) begin
               y.st.pct_digit = b;
               y.st.pct_cnt = 2'd2;
            end else begin
               y = emit_field(y, {hi.val, hx.val});
               y.st.pct_cnt = 2'd0;
               y.st.pct_digit = 8'd0;
            end
            done = 1'b1;
         end else begin
            y = emit_field(y, hrt_pkg::CH_PCT);
            if (y.st.pct_cnt == 2'd2) y = emit_field(y, y.st.pct_digit);
            y.st.pct_cnt = 2'd0;
            y.st.pct_digit = 8'd0;
         end
      end
      // colon held back in a key
      if (!done && y.st.phase == hrt_pkg::PH_KEY && y.st.pending_colon) begin
         y.st.pending_colon = 1'b0;
         if (b == hrt_pkg::CH_SP) begin
            y.st.phase = hrt_pkg::PH_VALUE;
            done = 1'b1;
         end else begin
            y = emit_field(y, hrt_pkg::CH_COLON);
         end
      end
      if (!done) begin
         if (b == hrt_pkg::CH_CR) begin
            y.st.pending_cr = 1'b1;
         end else begin
            unique case (y.st.phase)
               hrt_pkg::PH_METHOD: begin
                  if (b == hrt_pkg::CH_SP) y.st.phase = hrt_pkg::PH_URL;
                  else y = emit_field(y, b);
               end
               hrt_pkg::PH_URL: begin
                  if (b == hrt_pkg::CH_SP) y.st.phase = hrt_pkg::PH_VERSION;
                  else if (b == hrt_pkg::CH_PCT && en) y.st.pct_cnt = 2'd1;
                  else y = emit_field(y, b);
               end
               hrt_pkg::PH_KEY: begin
                  if (b == hrt_pkg::CH_COLON) y.st.pending_colon = 1'b1;
                  else y = emit_field(y, b);
               end
               default: begin
                  y = emit_field(y, b);
               end
            endcase
         end
      end
      return y;
   endfunction

   assign req_bus.ready = !q_full;
   assign accept = req_bus.valid && !q_full;

   always_comb begin
      w.st = st_ff;
      w.ent = '0;
      if (st_ff.pending_cr) begin
         w.st.pending_cr = 1'b0;
         if (req_bus.in_byte == hrt_pkg::CH_LF) begin
            w = line_end(w);
         end else begin
            w = emit_field(w, hrt_pkg::CH_CR);
            w = parse_byte(w, req_bus.in_byte, url_decode_enable);
         end
      end else begin
         w = parse_byte(w, req_bus.in_byte, url_decode_enable);
      end
      st_in = accept ? w.st : st_ff;
   end

   assign q_push = accept && (w.ent.cnt != '0);
   assign q_data = w.ent;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= '{phase: hrt_pkg::PH_METHOD, pending_cr: 1'b0, pending_colon: 1'b0,
                    pct_cnt: 2'd0, pct_digit: 8'd0, line_ne: 1'b0, key_ne: 1'b0,
                    val_ne: 1'b0};
      end else begin
         st_ff <= st_in;
      end
   end

endmodule

### rtl/core/hrt_back.sv
// back of the tokenizer: walks each queued result group and sends one
// result per beat through an output register; depends on hrt_pkg, hrt_rsp_if
`include "assert_macros.svh"

module hrt_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_empty,
   input  hrt_pkg::hrt_entry_type q_head,
   output logic                   q_pop,
   hrt_rsp_if.source              rsp_bus
);

   logic [hrt_pkg::CNT_W-1:0] sub_ff, sub_in;
   logic rsp_valid_ff, rsp_valid_in;
   hrt_pkg::hrt_result_type rsp_res_ff, rsp_res_in;
   logic rsp_last_ff, rsp_last_in;
   logic load;
   logic take;

   assign load = !rsp_valid_ff || rsp_bus.ready;
   assign take = load && !q_empty;
   assign q_pop = take && (sub_ff == q_head.cnt - 1'b1);

   always_comb begin
      sub_in = sub_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_res_in = rsp_res_ff;
      rsp_last_in = rsp_last_ff;
      if (load) begin
         rsp_valid_in = !q_empty;
      end
      if (take) begin
         rsp_res_in = q_head.res[sub_ff];
         rsp_last_in = q_pop;
         sub_in = q_pop ? '0 : sub_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sub_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sub_ff <= sub_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_res_ff <= rsp_res_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.out_byte = rsp_res_ff.data;
   assign rsp_bus.field_tag = rsp_res_ff.tag;
   assign rsp_bus.header_ok = rsp_res_ff.ok;
   assign rsp_bus.error_code = rsp_res_ff.err;
   assign rsp_bus.last = rsp_last_ff;

   `HRT_ASSERT(a_group_nonempty, !q_empty |-> (q_head.cnt != '0),
               "queued result group holds no result")
   `HRT_ASSERT(a_sub_in_range, !q_empty |-> (sub_ff < q_head.cnt),
               "result index past end of group")

endmodule

### rtl/core/http_request_tokenizer.sv
// path: a byte's results are queued, then sent to rsp_bus through the output register
// throughput: one byte per cycle while each byte yields at most one result and the queue
// is not full; the output register sends one result per cycle while rsp_bus is ready
// the queue of QUEUE_DEPTH result groups absorbs bursts of multi-result bytes
// reset: parse state to method phase, queue and output emptied, url decoding on
// top level: csr register, front, queue and back; depends on hrt_pkg and the interfaces
module http_request_tokenizer #(
   parameter int QUEUE_DEPTH = hrt_pkg::QUEUE_DEPTH
) (
   input  logic                            clock,
   input  logic                            reset,
   hrt_req_if.sink                         req_bus,
   hrt_rsp_if.source                       rsp_bus,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [hrt_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [hrt_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [hrt_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                            pready
);

   logic url_en_ff, url_en_in;
   logic q_push, q_pop, q_full, q_empty;
   hrt_pkg::hrt_entry_type q_data, q_head;

   assign pready = 1'b1;

   always_comb begin
      url_en_in = url_en_ff;
      if (psel && penable && pwrite && paddr == hrt_pkg::ADDR_URL_DECODE) begin
         url_en_in = pwdata[0];
      end
   end

   assign prdata = (paddr == hrt_pkg::ADDR_URL_DECODE) ?
                   hrt_pkg::CSR_DATA_W'(url_en_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         url_en_ff <= 1'b1;
      end else begin
         url_en_ff <= url_en_in;
      end
   end

   hrt_front u_front (
      .clock             (clock),
      .reset             (reset),
      .url_decode_enable (url_en_ff),
      .req_bus           (req_bus),
      .q_full            (q_full),
      .q_push            (q_push),
      .q_data            (q_data)
   );

   hrt_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_data),
      .full      (q_full),
      .pop       (q_pop),
      .head      (q_head),
      .empty     (q_empty)
   );

   hrt_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_empty (q_empty),
      .q_head  (q_head),
      .q_pop   (q_pop),
      .rsp_bus (rsp_bus)
   );

endmodule

### tb/tb_http_request_tokenizer.sv
// self-checking testbench for http_request_tokenizer: directed and random request streams
// with a cycle-free token predictor, random idling on both channels and csr changes when idle
// depends on hrt_pkg, hrt_req_if, hrt_rsp_if and the tokenizer rtl
`timescale 1ns / 100ps

module tb_http_request_tokenizer;

   localparam int RUN_LIMIT_NS = 400000;
   localparam int RSP_HOLD_CYCLES = 200;
   localparam int SETTLE_CYCLES = 8;
   localparam int RANDOM_BYTES = 230;

   typedef struct {
      logic [7:0]           data;
      hrt_pkg::hrt_tag_type tag;
      logic                 ok;
      logic                 err;
      logic                 last;
   } token_beat_type;

   class token_scoreboard;
      bit                     decode_on = 1'b1;
      hrt_pkg::hrt_phase_type phase = hrt_pkg::PH_METHOD;
      bit                     cr_held;
      bit                     colon_held;
      bit [1:0]               pct_seen;
      bit [7:0]               pct_hi;
      bit                     line_used;
      bit                     key_used;
      bit                     val_used;
      token_beat_type         step_out[$];
      token_beat_type         expected_tokens[$];
      int                     errors;
      int                     bytes_in;
      int                     beats_out;
      int                     tag_hits[8];

      function int hex_nibble(bit [7:0] c);
         if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
         if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h37;
         if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h57;
         return -1;
      endfunction

      function void put(bit [7:0] data, hrt_pkg::hrt_tag_type tag, bit ok, bit err);
         if (step_out.size() < hrt_pkg::MAX_RESULTS)
            step_out.push_back('{data, tag, ok, err, 1'b0});
      endfunction

      function void emit_field(bit [7:0] b);
         line_used = 1'b1;
         if (phase == hrt_pkg::PH_KEY) key_used = 1'b1;
         if (phase == hrt_pkg::PH_VALUE) val_used = 1'b1;
         put(b, hrt_pkg::hrt_tag_type'(phase), 1'b0, 1'b0);
      endfunction

      function void close_line();
         if (phase == hrt_pkg::PH_VERSION) begin
            put(8'h00, hrt_pkg::TAG_LINE_END, 1'b0, 1'b0);
            phase = hrt_pkg::PH_KEY;
         end else if (phase == hrt_pkg::PH_METHOD || phase == hrt_pkg::PH_URL) begin
            put(8'h00, hrt_pkg::TAG_ERROR, 1'b0, !line_used);
            phase = hrt_pkg::PH_METHOD;
         end else if (!line_used) begin
            put(8'h00, hrt_pkg::TAG_REQ_END, 1'b0, 1'b0);
            phase = hrt_pkg::PH_METHOD;
         end else begin
            put(8'h00, hrt_pkg::TAG_LINE_END,
                phase == hrt_pkg::PH_VALUE && key_used && val_used, 1'b0);
            phase = hrt_pkg::PH_KEY;
         end
         line_used = 1'b0;
         key_used = 1'b0;
         val_used = 1'b0;
         colon_held = 1'b0;
         pct_seen = 2'd0;
         pct_hi = 8'h00;
      endfunction

      function void absorb(bit [7:0] b);
         int lo;
         int hi;
         if (b != hrt_pkg::CH_CR) line_used = 1'b1;
         // escape in progress finishes regardless of the enable
         if (phase == hrt_pkg::PH_URL && pct_seen != 2'd0) begin
            lo = hex_nibble(b);
            if (lo >= 0) begin
               if (pct_seen == 2'd1) begin
                  pct_hi = b;
                  pct_seen = 2'd2;
               end else begin
                  hi = hex_nibble(pct_hi);
                  if (hi < 0) hi = 0;
                  emit_field(8'(hi * 16 + lo));
                  pct_seen = 2'd0;
                  pct_hi = 8'h00;
               end
               return;
            end
            emit_field(hrt_pkg::CH_PCT);
            if (pct_seen == 2'd2) emit_field(pct_hi);
            pct_seen = 2'd0;
            pct_hi = 8'h00;
         end
         if (phase == hrt_pkg::PH_KEY && colon_held) begin
            colon_held = 1'b0;
            if (b == hrt_pkg::CH_SP) begin
               phase = hrt_pkg::PH_VALUE;
               return;
            end
            emit_field(hrt_pkg::CH_COLON);
         end
         if (b == hrt_pkg::CH_CR) begin
            cr_held = 1'b1;
            return;
         end
         case (phase)
            hrt_pkg::PH_METHOD: begin
               if (b == hrt_pkg::CH_SP) phase = hrt_pkg::PH_URL;
               else emit_field(b);
            end
            hrt_pkg::PH_URL: begin
               if (b == hrt_pkg::CH_SP) phase = hrt_pkg::PH_VERSION;
               else if (b == hrt_pkg::CH_PCT && decode_on) pct_seen = 2'd1;
               else emit_field(b);
            end
            hrt_pkg::PH_KEY: begin
               if (b == hrt_pkg::CH_COLON) colon_held = 1'b1;
               else emit_field(b);
            end
            default: emit_field(b);
         endcase
      endfunction

      function void note_byte(bit [7:0] b);
         step_out.delete();
         bytes_in++;
         if (cr_held) begin
            cr_held = 1'b0;
            if (b == hrt_pkg::CH_LF) begin
               close_line();
            end else begin
               emit_field(hrt_pkg::CH_CR);
               absorb(b);
            end
         end else begin
            absorb(b);
         end
         if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
         foreach (step_out[i]) expected_tokens.push_back(step_out[i]);
      endfunction

      task report(string msg);
         errors++;
         if (errors <= 50) $display("%0t mismatch: %s", $realtime, msg);
      endtask

      task check_beat(logic [7:0] data, logic [2:0] tag, logic ok, logic err, logic last);
         token_beat_type want;
         beats_out++;
         if (expected_tokens.size() == 0) begin
            report($sformatf("unexpected beat %h/%0d/%b/%b/%b", data, tag, ok, err, last));
            return;
         end
         want = expected_tokens.pop_front();
         tag_hits[want.tag]++;
         if (data !== want.data || tag !== want.tag || ok !== want.ok || err !== want.err ||
             last !== want.last)
            report($sformatf("beat got %h/%0d/%b/%b/%b want %h/%0d/%b/%b/%b", data, tag, ok,
                             err, last, want.data, want.tag, want.ok, want.err, want.last));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic psel;
   logic penable;
   logic pwrite;
   logic [hrt_pkg::CSR_ADDR_W-1:0] paddr;
   logic [hrt_pkg::CSR_DATA_W-1:0] pwdata;
   logic [hrt_pkg::CSR_DATA_W-1:0] prdata;
   logic pready;

   hrt_req_if req_bus();
   hrt_rsp_if rsp_bus();

   token_scoreboard sb = new();
   logic [7:0] burst[$];
   bit calm;
   bit hold_rsp;
   int cfg_writes;

   http_request_tokenizer u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) sb.note_byte(req_bus.in_byte);
         if (rsp_bus.valid && rsp_bus.ready)
            sb.check_beat(rsp_bus.out_byte, rsp_bus.field_tag, rsp_bus.header_ok,
                          rsp_bus.error_code, rsp_bus.last);
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // result side: random stalls, calm stretches and one long hold-off
   initial begin
      int run;
      run = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_bus.ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
            rsp_bus.ready <= 1'b1;
            run = 0;
         end else if (calm) begin
            rsp_bus.ready <= 1'b1;
         end else if (run > 0) begin
            run--;
         end else if (!rsp_bus.ready) begin
            rsp_bus.ready <= 1'b1;
            run = $urandom_range(0, 15);
         end else begin
            rsp_bus.ready <= 1'b0;
            run = pick_gap();
         end
      end
   end

   function automatic logic [7:0] word_char();
      int r;
      r = $urandom_range(0, 9);
      if (r < 7) return 8'h61 + 8'($urandom_range(0, 25));
      if (r < 9) return 8'h30 + 8'($urandom_range(0, 9));
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [7:0] hex_char();
      string digits;
      digits = "0123456789abcdefABCDEF";
      return digits[$urandom_range(0, 21)];
   endfunction

   function automatic void push_byte(logic [7:0] b);
      burst.push_back(b);
   endfunction

   function automatic void push_text(string s);
      foreach (s[i]) burst.push_back(s[i]);
   endfunction

   function automatic void push_crlf();
      burst.push_back(hrt_pkg::CH_CR);
      burst.push_back(hrt_pkg::CH_LF);
   endfunction

   function automatic void push_word(int lo, int hi);
      repeat ($urandom_range(lo, hi)) burst.push_back(word_char());
   endfunction

   function automatic void push_url();
      int r;
      repeat ($urandom_range(1, 5)) begin
         r = $urandom_range(0, 9);
         if (r < 5) begin
            push_byte(word_char());
         end else if (r < 8) begin
            push_byte(hrt_pkg::CH_PCT);
            push_byte(hex_char());
            push_byte(hex_char());
         end else if (r < 9) begin
            push_byte(hrt_pkg::CH_PCT);
            push_byte(hex_char());
            push_byte(8'h67 + 8'($urandom_range(0, 10)));
         end else begin
            push_byte(hrt_pkg::CH_PCT);
         end
      end
   endfunction

   function automatic void push_request(bit broken);
      int r;
      push_word(1, 4);
      if (broken && $urandom_range(0, 1)) begin
         // request line short of a field
         if ($urandom_range(0, 1)) begin
            push_byte(hrt_pkg::CH_SP);
            push_url();
         end
         push_crlf();
         return;
      end
      push_byte(hrt_pkg::CH_SP);
      push_url();
      push_byte(hrt_pkg::CH_SP);
      if ($urandom_range(0, 1)) push_text("HTTP/1.1");
      else push_word(1, 3);
      push_crlf();
      repeat ($urandom_range(0, 3)) begin
         push_word(1, 4);
         r = $urandom_range(0, 9);
         if (r < 8) push_text(": ");
         else if (r < 9) push_byte(hrt_pkg::CH_COLON);
         push_word(0, 4);
         if ($urandom_range(0, 7) == 0) begin
            push_byte(hrt_pkg::CH_CR);
            push_word(1, 2);
         end
         push_crlf();
      end
      if (!broken || $urandom_range(0, 1)) push_crlf();
   endfunction

   function automatic void push_noise();
      repeat ($urandom_range(8, 20)) begin
         if ($urandom_range(0, 7) == 0) push_crlf();
         else push_byte(8'($urandom_range(0, 255)));
      end
   endfunction

   task automatic send_byte(input logic [7:0] b);
      int gap;
      req_bus.valid <= 1'b1;
      req_bus.in_byte <= b;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      gap = calm ? 0 : pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_burst();
      foreach (burst[i]) send_byte(burst[i]);
      burst.delete();
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (sb.expected_tokens.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_access(input bit wr, input logic [hrt_pkg::CSR_ADDR_W-1:0] addr,
                             input logic [hrt_pkg::CSR_DATA_W-1:0] data);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= wr;
      paddr <= addr;
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (!wr && prdata[0] !== data[0])
         sb.report($sformatf("csr %0d read %h want bit0 %b", addr, prdata, data[0]));
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_decode(input bit on);
      csr_access(1'b1, hrt_pkg::ADDR_URL_DECODE, {31'b0, on});
      sb.decode_on = on;
      cfg_writes++;
      csr_access(1'b0, hrt_pkg::ADDR_URL_DECODE, {31'b0, on});
   endtask

   initial begin
      #RUN_LIMIT_NS;
      $display("tb_http_request_tokenizer: errors");
      $finish;
   end

   initial begin
      int req_idx;
      int r;
      int stop_at;
      req_bus.valid = 1'b0;
      req_bus.in_byte = 8'h00;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      csr_access(1'b0, hrt_pkg::ADDR_URL_DECODE, 32'd1);

      // directed: empty and field-less request lines, escapes, odd headers
      push_crlf();
      push_byte(8'hFF);
      push_crlf();
      push_byte(8'h00);
      push_text(" %4g%2 ");
      push_byte(8'hFF);
      push_crlf();
      push_text("k:");
      push_byte(hrt_pkg::CH_CR);
      push_text("v");
      push_crlf();
      push_text("a: b");
      push_crlf();
      push_crlf();
      push_text("G %");
      send_burst();
      // decoding turned off with an escape already open
      drain();
      set_decode(1'b0);
      push_text("41 %");
      push_crlf();
      push_crlf();
      send_burst();
      drain();
      set_decode(1'b1);

      req_idx = 0;
      stop_at = sb.bytes_in + RANDOM_BYTES;
      while (sb.bytes_in < stop_at) begin
         calm = ($urandom_range(0, 4) == 0);
         if (req_idx % 4 == 3) begin
            drain();
            set_decode(!sb.decode_on);
         end
         if (req_idx == 2) begin
            hold_rsp = 1'b1;
            calm = 1'b1;
         end
         r = $urandom_range(0, 9);
         if (r < 7) push_request(1'b0);
         else if (r < 9) push_request(1'b1);
         else push_noise();
         send_burst();
         req_idx++;
      end
      calm = 1'b0;
      drain();

      $display("covered %0d request bytes, %0d result beats, %0d decode setting writes",
               sb.bytes_in, sb.beats_out, cfg_writes);
      $display("requests ended %0d, bad request lines %0d, line ends %0d",
               sb.tag_hits[hrt_pkg::TAG_REQ_END], sb.tag_hits[hrt_pkg::TAG_ERROR],
               sb.tag_hits[hrt_pkg::TAG_LINE_END]);
      if (sb.errors == 0)
         $display("tb_http_request_tokenizer: clean");
      else
         $display("tb_http_request_tokenizer: errors");
      $finish;
   end

endmodule
